// File: rtl/atilt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atilt_pkg
// Shared constants, register indexes and the arctangent table for the
// accelerometer tilt angle block.
// ----------------------------------------------------------------------------
package atilt_pkg;

    localparam int SAMPLE_BITS_DEF  = 10;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int ROOT_FRAC  = 15;
    localparam int ANGLE_FRAC = 16;
    localparam int ZW         = 25;
    localparam int ANGLE_W    = 8;
    localparam int DEG_MAX    = 90;

    localparam int OFFSET_X_RESET = 345;
    localparam int OFFSET_Y_RESET = 353;
    localparam int OFFSET_Z_RESET = 351;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_OFFSET_X = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y = 2'd1;
    localparam logic [1:0] REG_OFFSET_Z = 2'd2;

    // atan(2^-i) in degrees, Q16
    function automatic logic [21:0] atan_q16(input int i);
        logic [21:0] r;
        case (i)
            0:       r = 22'd2949120;
            1:       r = 22'd1740967;
            2:       r = 22'd919879;
            3:       r = 22'd466945;
            4:       r = 22'd234379;
            5:       r = 22'd117304;
            6:       r = 22'd58666;
            7:       r = 22'd29335;
            8:       r = 22'd14668;
            9:       r = 22'd7334;
            10:      r = 22'd3667;
            11:      r = 22'd1833;
            12:      r = 22'd917;
            13:      r = 22'd458;
            14:      r = 22'd229;
            15:      r = 22'd115;
            16:      r = 22'd57;
            17:      r = 22'd29;
            18:      r = 22'd14;
            19:      r = 22'd7;
            20:      r = 22'd4;
            21:      r = 22'd2;
            22:      r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/atilt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atilt_front
// Offset removal, squaring and square sums: three register stages.
// Lane 0 carries dx with dy^2+dz^2, lane 1 carries dy with dx^2+dz^2.
// ----------------------------------------------------------------------------
module atilt_front
    import atilt_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [SAMPLE_BITS-1:0]   sample_x,
    input  logic [SAMPLE_BITS-1:0]   sample_y,
    input  logic [SAMPLE_BITS-1:0]   sample_z,
    input  logic [SAMPLE_BITS-1:0]   offset_x,
    input  logic [SAMPLE_BITS-1:0]   offset_y,
    input  logic [SAMPLE_BITS-1:0]   offset_z,
    output logic                     out_valid,
    output logic signed [SAMPLE_BITS:0]     num [2],
    output logic [2*SAMPLE_BITS:0]   sum [2]
);

    localparam int DW  = SAMPLE_BITS + 1;
    localparam int SQ  = 2 * SAMPLE_BITS;
    localparam int SQW = SQ + 1;

    logic [2:0]            valid_reg;
    logic signed [DW-1:0]  dx_reg, dy_reg, dz_reg;
    logic signed [DW-1:0]  dx2_reg, dy2_reg;
    logic [SQ-1:0]         sx_reg, sy_reg, sz_reg;
    logic signed [DW-1:0]  dx3_reg, dy3_reg;
    logic [SQW-1:0]        sumx_reg, sumy_reg;
    logic signed [2*DW-1:0] px, py, pz;

    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;
    assign pz = dz_reg * dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= $signed({1'b0, sample_x}) - $signed({1'b0, offset_x});
            dy_reg   <= $signed({1'b0, sample_y}) - $signed({1'b0, offset_y});
            dz_reg   <= $signed({1'b0, sample_z}) - $signed({1'b0, offset_z});
            dx2_reg  <= dx_reg;
            dy2_reg  <= dy_reg;
            sx_reg   <= px[SQ-1:0];
            sy_reg   <= py[SQ-1:0];
            sz_reg   <= pz[SQ-1:0];
            dx3_reg  <= dx2_reg;
            dy3_reg  <= dy2_reg;
            sumx_reg <= {1'b0, sy_reg} + {1'b0, sz_reg};
            sumy_reg <= {1'b0, sx_reg} + {1'b0, sz_reg};
        end
    end

    assign out_valid = valid_reg[2];
    assign num[0]    = dx3_reg;
    assign num[1]    = dy3_reg;
    assign sum[0]    = sumx_reg;
    assign sum[1]    = sumy_reg;

endmodule

// File: rtl/atilt_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atilt_sqrt
// Digit-by-digit square root of sum * 2^30, one root bit per stage, two lanes.
// ----------------------------------------------------------------------------
module atilt_sqrt
    import atilt_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [SAMPLE_BITS:0]  in_num [2],
    input  logic [2*SAMPLE_BITS:0]       in_sum [2],
    output logic                         out_valid,
    output logic signed [SAMPLE_BITS:0]  out_num [2],
    output logic                         out_zero [2],
    output logic [SAMPLE_BITS+15:0]      out_root [2]
);

    localparam int DW  = SAMPLE_BITS + 1;
    localparam int SQW = 2 * SAMPLE_BITS + 1;
    localparam int RW  = SAMPLE_BITS + ROOT_FRAC + 1;
    localparam int VW  = 2 * RW;
    localparam int PAD = VW - SQW - 2 * ROOT_FRAC;

    logic [RW-1:0]   valid_reg;
    logic [RW+1:0]   rem_reg  [RW][2];
    logic [RW-1:0]   root_reg [RW][2];
    logic [VW-1:0]   v_reg    [RW][2];
    logic signed [DW-1:0] num_reg [RW][2];
    logic            zero_reg [RW][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[RW-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [RW+1:0]        rem_in;
            logic [RW-1:0]        root_in;
            logic [VW-1:0]        v_in;
            logic signed [DW-1:0] num_in;
            logic                 zero_in;
            logic [RW+1:0]        cur, trial;
            logic                 ge;

            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign v_in    = {{PAD{1'b0}}, in_sum[l], {(2*ROOT_FRAC){1'b0}}};
                assign num_in  = in_num[l];
                assign zero_in = (in_sum[l] == '0);
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[k-1][l];
                assign root_in = root_reg[k-1][l];
                assign v_in    = v_reg[k-1][l];
                assign num_in  = num_reg[k-1][l];
                assign zero_in = zero_reg[k-1][l];
            end

            assign cur   = {rem_in[RW-1:0], v_in[VW-1 -: 2]};
            assign trial = {root_in, 2'b01};
            assign ge    = (cur >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k][l]  <= ge ? (cur - trial) : cur;
                    root_reg[k][l] <= {root_in[RW-2:0], ge};
                    v_reg[k][l]    <= {v_in[VW-3:0], 2'b00};
                    num_reg[k][l]  <= num_in;
                    zero_reg[k][l] <= zero_in;
                end
            end
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_out
        assign out_num[l]  = num_reg[RW-1][l];
        assign out_zero[l] = zero_reg[RW-1][l];
        assign out_root[l] = root_reg[RW-1][l];
    end

    assign out_valid = valid_reg[RW-1];

endmodule

// File: rtl/atilt_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atilt_cordic
// Vectoring CORDIC, one iteration per stage, two lanes, Q16 degree angle.
// ----------------------------------------------------------------------------
module atilt_cordic
    import atilt_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [SAMPLE_BITS:0]  in_num [2],
    input  logic                         in_zero [2],
    input  logic [SAMPLE_BITS+15:0]      in_root [2],
    output logic                         out_valid,
    output logic signed [ZW-1:0]         out_z [2],
    output logic                         out_neg [2],
    output logic                         out_nz [2],
    output logic                         out_zero [2]
);

    localparam int DW = SAMPLE_BITS + 1;
    localparam int RW = SAMPLE_BITS + ROOT_FRAC + 1;
    localparam int CW = RW + 3;

    logic [CORDIC_STEPS-1:0] valid_reg;
    logic signed [CW-1:0] x_reg [CORDIC_STEPS][2];
    logic signed [CW-1:0] y_reg [CORDIC_STEPS][2];
    logic signed [ZW-1:0] z_reg [CORDIC_STEPS][2];
    logic                 neg_reg  [CORDIC_STEPS][2];
    logic                 nz_reg   [CORDIC_STEPS][2];
    logic                 zero_reg [CORDIC_STEPS][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[CORDIC_STEPS-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_stage
        localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q16(k));
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic signed [CW-1:0] x_in, y_in, ex, ey;
            logic signed [ZW-1:0] z_in;
            logic                 neg_in, nz_in, zero_in;

            if (k == 0)
            begin : g_first
                logic [DW-1:0] mag;
                assign mag     = in_num[l][DW-1] ? DW'(-in_num[l]) : DW'(in_num[l]);
                assign x_in    = $signed(CW'(in_root[l]));
                assign y_in    = $signed({{(CW-DW-ROOT_FRAC){1'b0}}, mag,
                                          {ROOT_FRAC{1'b0}}});
                assign z_in    = '0;
                assign neg_in  = in_num[l][DW-1];
                assign nz_in   = (in_num[l] != '0);
                assign zero_in = in_zero[l];
            end
            else
            begin : g_next
                assign x_in    = x_reg[k-1][l];
                assign y_in    = y_reg[k-1][l];
                assign z_in    = z_reg[k-1][l];
                assign neg_in  = neg_reg[k-1][l];
                assign nz_in   = nz_reg[k-1][l];
                assign zero_in = zero_reg[k-1][l];
            end

            assign ex = y_in >>> k;
            assign ey = x_in >>> k;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (y_in > 0)
                    begin
                        x_reg[k][l] <= x_in + ex;
                        y_reg[k][l] <= y_in - ey;
                        z_reg[k][l] <= z_in + ATAN;
                    end
                    else if (y_in < 0)
                    begin
                        x_reg[k][l] <= x_in - ex;
                        y_reg[k][l] <= y_in + ey;
                        z_reg[k][l] <= z_in - ATAN;
                    end
                    else
                    begin
                        x_reg[k][l] <= x_in;
                        y_reg[k][l] <= y_in;
                        z_reg[k][l] <= z_in;
                    end
                    neg_reg[k][l]  <= neg_in;
                    nz_reg[k][l]   <= nz_in;
                    zero_reg[k][l] <= zero_in;
                end
            end
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_out
        assign out_z[l]    = z_reg[CORDIC_STEPS-1][l];
        assign out_neg[l]  = neg_reg[CORDIC_STEPS-1][l];
        assign out_nz[l]   = nz_reg[CORDIC_STEPS-1][l];
        assign out_zero[l] = zero_reg[CORDIC_STEPS-1][l];
    end

    assign out_valid = valid_reg[CORDIC_STEPS-1];

endmodule

// File: rtl/accel_tilt_angles_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_angles_top
// Tilt angles in whole degrees from one three-axis accelerometer sample set.
//
// Input stream s_*: one sample set per item, x, y, z packed from bit 0.
// Output stream m_*: tilt_x_deg in bits 7:0, tilt_y_deg in bits 15:8.
// APB port: offset_x at 0x0, offset_y at 0x4, offset_z at 0x8.
// Throughput: one item per cycle while the output does not stall, fully pipelined.
// Pipeline: 3 front stages, SAMPLE_BITS+16 root stages (one root bit each),
// CORDIC_STEPS rotation stages and the output register.
// Reset clears all valid bits and loads the default offsets.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; no item is lost or repeated.
// ----------------------------------------------------------------------------
module accel_tilt_angles_top
    import atilt_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // sample_x, sample_y, sample_z
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tilt_x_deg, tilt_y_deg
    output logic [2*ANGLE_W-1:0]   m_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int SB = SAMPLE_BITS;

    logic [SB-1:0] off_x_reg, off_y_reg, off_z_reg;
    logic          en;

    logic                   f_valid;
    logic signed [SB:0]     f_num [2];
    logic [2*SB:0]          f_sum [2];

    logic                   r_valid;
    logic signed [SB:0]     r_num [2];
    logic                   r_zero [2];
    logic [SB+15:0]         r_root [2];

    logic                   c_valid;
    logic signed [ZW-1:0]   c_z [2];
    logic                   c_neg [2], c_nz [2], c_zero [2];

    logic [ANGLE_W-1:0]     angle [2];
    logic                   out_valid_reg;
    logic [2*ANGLE_W-1:0]   out_data_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg <= SB'(OFFSET_X_RESET);
            off_y_reg <= SB'(OFFSET_Y_RESET);
            off_z_reg <= SB'(OFFSET_Z_RESET);
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_OFFSET_X: off_x_reg <= pwdata[SB-1:0];
                REG_OFFSET_Y: off_y_reg <= pwdata[SB-1:0];
                REG_OFFSET_Z: off_z_reg <= pwdata[SB-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_OFFSET_X: prdata = APB_DATA_W'(off_x_reg);
            REG_OFFSET_Y: prdata = APB_DATA_W'(off_y_reg);
            REG_OFFSET_Z: prdata = APB_DATA_W'(off_z_reg);
            default:      prdata = '0;
        endcase
    end

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    atilt_front #(.SAMPLE_BITS(SB)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .sample_x  (s_tdata[SB-1:0]),
        .sample_y  (s_tdata[2*SB-1:SB]),
        .sample_z  (s_tdata[3*SB-1:2*SB]),
        .offset_x  (off_x_reg),
        .offset_y  (off_y_reg),
        .offset_z  (off_z_reg),
        .out_valid (f_valid),
        .num       (f_num),
        .sum       (f_sum)
    );

    atilt_sqrt #(.SAMPLE_BITS(SB)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_num    (f_num),
        .in_sum    (f_sum),
        .out_valid (r_valid),
        .out_num   (r_num),
        .out_zero  (r_zero),
        .out_root  (r_root)
    );

    atilt_cordic #(.SAMPLE_BITS(SB), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .in_num    (r_num),
        .in_zero   (r_zero),
        .in_root   (r_root),
        .out_valid (c_valid),
        .out_z     (c_z),
        .out_neg   (c_neg),
        .out_nz    (c_nz),
        .out_zero  (c_zero)
    );

    for (genvar l = 0; l < 2; l++)
    begin : g_conv
        logic [ANGLE_W-1:0] deg, deg_c;
        assign deg   = c_z[l][ZW-1] ? '0 : c_z[l][ZW-2:ANGLE_FRAC];
        assign deg_c = (deg > ANGLE_W'(DEG_MAX)) ? ANGLE_W'(DEG_MAX) : deg;
        always_comb
        begin
            if (c_zero[l])
            begin
                angle[l] = c_nz[l] ? (c_neg[l] ? -ANGLE_W'(DEG_MAX) : ANGLE_W'(DEG_MAX))
                                   : '0;
            end
            else
            begin
                angle[l] = c_neg[l] ? -deg_c : deg_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {angle[1], angle[0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
